// ===== hdl/prime_field_arith_unit_assert.svh =====
// assertion macros shared by the prime field arithmetic unit modules
`ifndef PRIME_FIELD_ARITH_UNIT_ASSERT_SVH
`define PRIME_FIELD_ARITH_UNIT_ASSERT_SVH

// condition holds at every edge out of reset
`define PFA_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define PFA_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/pfa_pkg.sv =====
// constants, codes and controller/datapath interface types for the prime field unit
package pfa_pkg;

    localparam int FIELD_W = 30;
    localparam int EXPONENT_BITS_DEFAULT = 63;
    // bit length of the fixed inverse exponent (modulus - 2)
    localparam int INV_EXP_BITS = 30;

    localparam logic [FIELD_W-1:0] FIELD_MOD = 30'd998244353;
    localparam logic [FIELD_W-1:0] FIELD_MOD_MINUS2 = 30'd998244351;
    localparam logic [31:0] FIELD_MOD_X2 = 32'd1996488706;
    // barrett constant floor(2^60 / modulus)
    localparam logic [30:0] BARRETT_MU = 31'((64'd1 << 60) / 64'd998244353);

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_POW = 3'd4;
    localparam logic [2:0] OP_NEG = 3'd5;
    localparam logic [2:0] OP_INV = 3'd6;

    typedef enum logic [1:0] {
        TAG_SQ,
        TAG_ACC,
        TAG_FIN
    } mul_tag_t;

    typedef struct packed {
        logic capture;
        logic init_pow;
        logic issue_sq;
        logic issue_acc;
        logic issue_final;
        logic final_use_acc;
        logic shift_exp;
        logic finish_simple;
        logic finish_acc;
    } pfa_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       exp_lsb;
        logic       mul_busy;
    } pfa_status_t;

endpackage

// ===== hdl/pfa_modmul.sv =====
// five-stage barrett modular multiplier modulo 998244353
`include "prime_field_arith_unit_assert.svh"

module pfa_modmul (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  pfa_pkg::mul_tag_t             in_tag,
    input  logic [pfa_pkg::FIELD_W-1:0]   in_x,
    input  logic [pfa_pkg::FIELD_W-1:0]   in_y,
    output logic                          out_valid,
    output pfa_pkg::mul_tag_t             out_tag,
    output logic [pfa_pkg::FIELD_W-1:0]   out_data,
    output logic                          busy
);

    logic [4:0]              valid_reg;
    logic [4:0]              valid_next;
    pfa_pkg::mul_tag_t       tag_reg [5];

    logic [59:0] prod_reg;
    logic [59:0] prod_next;
    logic [61:0] quot_reg;
    logic [61:0] quot_next;
    logic [31:0] xlo2_reg;
    logic [31:0] xlo3_reg;
    logic [60:0] qp_full;
    logic [31:0] qp_reg;
    logic [31:0] rem_reg;
    logic [31:0] rem_next;
    logic [pfa_pkg::FIELD_W-1:0] res_reg;
    logic [pfa_pkg::FIELD_W-1:0] res_next;

    assign valid_next = {valid_reg[3:0], in_valid};
    assign prod_next  = in_x * in_y;
    assign quot_next  = prod_reg[59:29] * pfa_pkg::BARRETT_MU;
    assign qp_full    = quot_reg[61:31] * pfa_pkg::FIELD_MOD;
    // quotient estimate is short by at most two, so the remainder is below 3*mod
    assign rem_next   = xlo3_reg - qp_reg;

    always_comb
    begin
        if (rem_reg >= pfa_pkg::FIELD_MOD_X2)
        begin
            res_next = pfa_pkg::FIELD_W'(rem_reg - pfa_pkg::FIELD_MOD_X2);
        end
        else if (rem_reg >= 32'(pfa_pkg::FIELD_MOD))
        begin
            res_next = pfa_pkg::FIELD_W'(rem_reg - 32'(pfa_pkg::FIELD_MOD));
        end
        else
        begin
            res_next = pfa_pkg::FIELD_W'(rem_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg[0] <= in_tag;
        for (int i = 1; i < 5; i++)
        begin
            tag_reg[i] <= tag_reg[i-1];
        end
        prod_reg <= prod_next;
        quot_reg <= quot_next;
        xlo2_reg <= prod_reg[31:0];
        xlo3_reg <= xlo2_reg;
        qp_reg   <= qp_full[31:0];
        rem_reg  <= rem_next;
        res_reg  <= res_next;
    end

    assign out_valid = valid_reg[4];
    assign out_tag   = tag_reg[4];
    assign out_data  = res_reg;
    assign busy      = |valid_reg;

    `PFA_ASSERT_IMPLY(a_mul_reduced, out_valid, out_data < pfa_pkg::FIELD_MOD,
        "modmul output not reduced")
    `PFA_ASSERT_HOLDS(a_mul_depth, $countones(valid_reg) <= 2,
        "more than two products in flight")

endmodule

// ===== hdl/pfa_dp.sv =====
// datapath: operand capture, add/sub/negate, power registers and the shared multiplier
`include "prime_field_arith_unit_assert.svh"

module pfa_dp #(
    parameter int EXPONENT_BITS = pfa_pkg::EXPONENT_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pfa_pkg::pfa_cmd_t             cmd,
    output pfa_pkg::pfa_status_t          sts,
    input  logic [2:0]                    operation,
    input  logic [pfa_pkg::FIELD_W-1:0]   left_operand,
    input  logic [pfa_pkg::FIELD_W-1:0]   right_operand,
    input  logic [EXPONENT_BITS-1:0]      exponent,
    output logic                          done,
    output logic [pfa_pkg::FIELD_W-1:0]   result
);

    localparam int EXP_W = (EXPONENT_BITS > pfa_pkg::INV_EXP_BITS) ?
                           EXPONENT_BITS : pfa_pkg::INV_EXP_BITS;
    localparam int FW = pfa_pkg::FIELD_W;

    logic [2:0]       op_reg;
    logic [2:0]       op_next;
    logic [FW-1:0]    a_reg;
    logic [FW-1:0]    a_next;
    logic [FW-1:0]    b_reg;
    logic [FW-1:0]    b_next;
    logic [EXP_W-1:0] exp_reg;
    logic [EXP_W-1:0] exp_next;
    logic [FW-1:0]    acc_reg;
    logic [FW-1:0]    acc_next;
    logic [FW-1:0]    sq_reg;
    logic [FW-1:0]    sq_next;
    logic [FW-1:0]    result_reg;
    logic [FW-1:0]    result_next;
    logic             done_reg;
    logic             done_next;

    logic [FW-1:0]    a_red;
    logic [FW-1:0]    b_red;
    logic [FW:0]      sum;
    logic [FW-1:0]    sum_wrap;
    logic [FW-1:0]    simple_val;

    logic              mul_in_valid;
    pfa_pkg::mul_tag_t mul_in_tag;
    logic [FW-1:0]     mul_x;
    logic [FW-1:0]     mul_y;
    logic              mul_out_valid;
    pfa_pkg::mul_tag_t mul_out_tag;
    logic [FW-1:0]     mul_out;
    logic              mul_busy;

    assign a_red = (left_operand >= pfa_pkg::FIELD_MOD) ?
                   left_operand - pfa_pkg::FIELD_MOD : left_operand;
    assign b_red = (right_operand >= pfa_pkg::FIELD_MOD) ?
                   right_operand - pfa_pkg::FIELD_MOD : right_operand;

    // subtract adds the complement of b so one wrap step serves both
    always_comb
    begin
        if (op_reg == pfa_pkg::OP_SUB)
        begin
            sum = {1'b0, a_reg} + {1'b0, pfa_pkg::FIELD_MOD - b_reg};
        end
        else
        begin
            sum = {1'b0, a_reg} + {1'b0, b_reg};
        end
        if (sum >= {1'b0, pfa_pkg::FIELD_MOD})
        begin
            sum_wrap = FW'(sum - {1'b0, pfa_pkg::FIELD_MOD});
        end
        else
        begin
            sum_wrap = FW'(sum);
        end
    end

    always_comb
    begin
        case (op_reg)
            pfa_pkg::OP_ADD, pfa_pkg::OP_SUB:
            begin
                simple_val = sum_wrap;
            end
            pfa_pkg::OP_NEG:
            begin
                simple_val = (a_reg == '0) ? '0 : pfa_pkg::FIELD_MOD - a_reg;
            end
            default:
            begin
                simple_val = '0;
            end
        endcase
    end

    always_comb
    begin
        mul_in_valid = cmd.issue_sq | cmd.issue_acc | cmd.issue_final;
        mul_in_tag   = pfa_pkg::TAG_SQ;
        mul_x        = sq_reg;
        mul_y        = sq_reg;
        if (cmd.issue_acc)
        begin
            mul_in_tag = pfa_pkg::TAG_ACC;
            mul_x      = acc_reg;
        end
        else if (cmd.issue_final)
        begin
            mul_in_tag = pfa_pkg::TAG_FIN;
            mul_x      = a_reg;
            mul_y      = cmd.final_use_acc ? acc_reg : b_reg;
        end
    end

    pfa_modmul u_modmul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mul_in_valid),
        .in_tag    (mul_in_tag),
        .in_x      (mul_x),
        .in_y      (mul_y),
        .out_valid (mul_out_valid),
        .out_tag   (mul_out_tag),
        .out_data  (mul_out),
        .busy      (mul_busy)
    );

    always_comb
    begin
        op_next     = op_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        exp_next    = exp_reg;
        acc_next    = acc_reg;
        sq_next     = sq_reg;
        result_next = result_reg;
        done_next   = 1'b0;

        if (cmd.capture)
        begin
            op_next  = operation;
            a_next   = a_red;
            b_next   = b_red;
            exp_next = (operation == pfa_pkg::OP_POW) ? EXP_W'(exponent) :
                       EXP_W'(pfa_pkg::FIELD_MOD_MINUS2);
        end
        if (cmd.init_pow)
        begin
            acc_next = FW'(1);
            sq_next  = (op_reg == pfa_pkg::OP_DIV) ? b_reg : a_reg;
        end
        if (cmd.shift_exp)
        begin
            exp_next = exp_reg >> 1;
        end
        if (cmd.finish_simple)
        begin
            result_next = simple_val;
            done_next   = 1'b1;
        end
        if (cmd.finish_acc)
        begin
            result_next = acc_reg;
            done_next   = 1'b1;
        end
        if (mul_out_valid)
        begin
            case (mul_out_tag)
                pfa_pkg::TAG_SQ:
                begin
                    sq_next = mul_out;
                end
                pfa_pkg::TAG_ACC:
                begin
                    acc_next = mul_out;
                end
                pfa_pkg::TAG_FIN:
                begin
                    result_next = mul_out;
                    done_next   = 1'b1;
                end
                default:
                begin
                    sq_next = sq_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        exp_reg    <= exp_next;
        acc_reg    <= acc_next;
        sq_reg     <= sq_next;
        result_reg <= result_next;
    end

    assign sts.op       = op_reg;
    assign sts.exp_lsb  = exp_reg[0];
    assign sts.mul_busy = mul_busy;
    assign done         = done_reg;
    assign result       = result_reg;

    `PFA_ASSERT_IMPLY(a_dp_result_reduced, done_reg, result_reg < pfa_pkg::FIELD_MOD,
        "result word not reduced")

endmodule

// ===== hdl/pfa_ctrl.sv =====
// controller state machine sequencing capture, square-and-multiply and result strobe
`include "prime_field_arith_unit_assert.svh"

module pfa_ctrl #(
    parameter int EXPONENT_BITS = pfa_pkg::EXPONENT_BITS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    output pfa_pkg::pfa_cmd_t    cmd,
    input  pfa_pkg::pfa_status_t sts
);

    localparam int EXP_W = (EXPONENT_BITS > pfa_pkg::INV_EXP_BITS) ?
                           EXPONENT_BITS : pfa_pkg::INV_EXP_BITS;
    localparam int CNT_W = $clog2(EXP_W + 1);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_SQ       = 3'd2;
    localparam logic [2:0] S_ACC      = 3'd3;
    localparam logic [2:0] S_WAIT     = 3'd4;
    localparam logic [2:0] S_END      = 3'd5;
    localparam logic [2:0] S_WAIT_FIN = 3'd6;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (sts.op)
                    pfa_pkg::OP_MUL:
                    begin
                        cmd.issue_final = 1'b1;
                        state_next      = S_WAIT_FIN;
                    end
                    pfa_pkg::OP_POW:
                    begin
                        cmd.init_pow = 1'b1;
                        cnt_next     = CNT_W'(EXPONENT_BITS);
                        state_next   = S_SQ;
                    end
                    pfa_pkg::OP_DIV, pfa_pkg::OP_INV:
                    begin
                        cmd.init_pow = 1'b1;
                        cnt_next     = CNT_W'(pfa_pkg::INV_EXP_BITS);
                        state_next   = S_SQ;
                    end
                    default:
                    begin
                        cmd.finish_simple = 1'b1;
                        state_next        = S_IDLE;
                    end
                endcase
            end
            S_SQ:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = S_END;
                end
                else
                begin
                    cmd.issue_sq = 1'b1;
                    state_next   = sts.exp_lsb ? S_ACC : S_WAIT;
                end
            end
            S_ACC:
            begin
                // reads the square from before this bit, issued in the cycle after the square
                cmd.issue_acc = 1'b1;
                state_next    = S_WAIT;
            end
            S_WAIT:
            begin
                if (!sts.mul_busy)
                begin
                    cmd.shift_exp = 1'b1;
                    cnt_next      = cnt_reg - CNT_W'(1);
                    state_next    = S_SQ;
                end
            end
            S_END:
            begin
                if (sts.op == pfa_pkg::OP_DIV)
                begin
                    cmd.issue_final   = 1'b1;
                    cmd.final_use_acc = 1'b1;
                    state_next        = S_WAIT_FIN;
                end
                else
                begin
                    cmd.finish_acc = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_WAIT_FIN:
            begin
                if (!sts.mul_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    `PFA_ASSERT_NEXT(a_ctrl_accept, start && !busy, state_reg == S_DISPATCH,
        "accepted word did not reach dispatch")
    `PFA_ASSERT_HOLDS(a_ctrl_one_cmd,
        $onehot0({cmd.capture, cmd.init_pow, cmd.issue_sq, cmd.issue_acc,
                  cmd.issue_final, cmd.shift_exp, cmd.finish_simple, cmd.finish_acc}),
        "more than one datapath command in a cycle")

endmodule

// ===== hdl/prime_field_arith_unit.sv =====
// Prime field arithmetic unit mod 998244353: one word in, one result word out.
// Add, subtract, negate skip the multiplier. Multiply: one pass through the five-stage
// shared multiplier. Power: a square per exponent bit and a multiply per one bit over
// EXPONENT_BITS bits, each bit waiting for the multiplier to drain; invert over 30
// bits, divide adds a final multiply. One word at a time, the next taken no earlier
// than the result strobe; done cannot stall. Reset clears control state only.
module prime_field_arith_unit #(
    parameter int EXPONENT_BITS = pfa_pkg::EXPONENT_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [2:0]                    operation,
    input  logic [pfa_pkg::FIELD_W-1:0]   left_operand,
    input  logic [pfa_pkg::FIELD_W-1:0]   right_operand,
    input  logic [EXPONENT_BITS-1:0]      exponent,
    output logic                          done,
    output logic [pfa_pkg::FIELD_W-1:0]   result
);

    pfa_pkg::pfa_cmd_t    cmd;
    pfa_pkg::pfa_status_t sts;

    pfa_ctrl #(
        .EXPONENT_BITS (EXPONENT_BITS)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .sts   (sts)
    );

    pfa_dp #(
        .EXPONENT_BITS (EXPONENT_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .operation     (operation),
        .left_operand  (left_operand),
        .right_operand (right_operand),
        .exponent      (exponent),
        .done          (done),
        .result        (result)
    );

endmodule

// ===== sim/tb_prime_field_arith_unit.sv =====
// testbench for the prime field unit: directed table, then random words checked by a predictor
module tb_prime_field_arith_unit;

    localparam int FW = pfa_pkg::FIELD_W;
    localparam int EXP_W = pfa_pkg::EXPONENT_BITS_DEFAULT;
    localparam logic [2:0] OP_RESERVED = 3'd7;
    localparam logic [FW-1:0] FIELD_MAX = {FW{1'b1}};
    localparam logic [FW-1:0] FIELD_TOP = pfa_pkg::FIELD_MOD - 30'd1;
    localparam int WORDS_PER_PHASE = 500;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 600;
    localparam int NUM_ROWS = 25;

    typedef struct packed {
        logic [2:0]       op;
        logic [FW-1:0]    lhs;
        logic [FW-1:0]    rhs;
        logic [EXP_W-1:0] power_exp;
        logic             fixed;
        logic [FW-1:0]    want;
    } word_row_t;

    typedef struct packed {
        logic [2:0]    op;
        logic [FW-1:0] want;
    } pending_t;

    // fixed rows carry a result readable by hand, the rest go through the predictor
    localparam word_row_t DIRECTED_ROWS [0:NUM_ROWS-1] = '{
        '{pfa_pkg::OP_ADD, 30'd0, 30'd0, 63'd0, 1'b1, 30'd0},
        '{pfa_pkg::OP_ADD, pfa_pkg::FIELD_MOD, 30'd0, 63'd0, 1'b1, 30'd0},
        '{pfa_pkg::OP_ADD, FIELD_MAX, FIELD_MAX, {EXP_W{1'b1}}, 1'b0, 30'd0},
        '{pfa_pkg::OP_ADD, FIELD_TOP, 30'd1, 63'd0, 1'b1, 30'd0},
        '{pfa_pkg::OP_SUB, 30'd0, 30'd1, 63'd0, 1'b1, FIELD_TOP},
        '{pfa_pkg::OP_SUB, FIELD_MAX, 30'd0, 63'd0, 1'b0, 30'd0},
        '{pfa_pkg::OP_SUB, FIELD_TOP, FIELD_TOP, 63'd0, 1'b1, 30'd0},
        '{pfa_pkg::OP_MUL, FIELD_TOP, FIELD_TOP, 63'd0, 1'b1, 30'd1},
        '{pfa_pkg::OP_MUL, FIELD_MAX, FIELD_MAX, 63'd0, 1'b0, 30'd0},
        '{pfa_pkg::OP_DIV, 30'd5, 30'd0, 63'd0, 1'b1, 30'd0},
        '{pfa_pkg::OP_DIV, 30'd7, pfa_pkg::FIELD_MOD, 63'd0, 1'b1, 30'd0},
        '{pfa_pkg::OP_DIV, FIELD_MAX, 30'd3, 63'd0, 1'b0, 30'd0},
        '{pfa_pkg::OP_POW, 30'd0, 30'd0, 63'd0, 1'b1, 30'd1},
        '{pfa_pkg::OP_POW, FIELD_MAX, FIELD_MAX, 63'd0, 1'b1, 30'd1},
        '{pfa_pkg::OP_POW, 30'd2, 30'd0, {EXP_W{1'b1}}, 1'b0, 30'd0},
        '{pfa_pkg::OP_POW, 30'd0, 30'd9, 63'd5, 1'b1, 30'd0},
        '{pfa_pkg::OP_POW, 30'd3, 30'd0, 63'(FIELD_TOP), 1'b1, 30'd1},
        '{pfa_pkg::OP_NEG, 30'd0, FIELD_MAX, 63'd0, 1'b1, 30'd0},
        '{pfa_pkg::OP_NEG, 30'd1, 30'd0, 63'd0, 1'b1, FIELD_TOP},
        '{pfa_pkg::OP_NEG, FIELD_MAX, 30'd0, 63'd0, 1'b0, 30'd0},
        '{pfa_pkg::OP_INV, 30'd0, 30'd0, 63'd0, 1'b1, 30'd0},
        '{pfa_pkg::OP_INV, 30'd1, 30'd0, 63'd0, 1'b1, 30'd1},
        '{pfa_pkg::OP_INV, FIELD_TOP, 30'd0, 63'd0, 1'b1, FIELD_TOP},
        '{pfa_pkg::OP_INV, FIELD_MAX, 30'h2AAA_AAAA, {EXP_W{1'b1}}, 1'b0, 30'd0},
        '{OP_RESERVED, 30'd12345, 30'd678, 63'd9, 1'b1, 30'd0}
    };

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [2:0]          operation = pfa_pkg::OP_ADD;
    logic [FW-1:0]       left_operand = '0;
    logic [FW-1:0]       right_operand = '0;
    logic [EXP_W-1:0]    exponent = '0;
    logic                done;
    logic [FW-1:0]       result;

    pending_t pending_results[$];
    int mismatch_count = 0;

    always #10 clk = ~clk;

    prime_field_arith_unit #(
        .EXPONENT_BITS(EXP_W)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .operation(operation),
        .left_operand(left_operand),
        .right_operand(right_operand),
        .exponent(exponent),
        .done(done),
        .result(result)
    );

    function automatic logic [FW-1:0] fold_operand(logic [FW-1:0] v);
        return (v >= pfa_pkg::FIELD_MOD) ? v - pfa_pkg::FIELD_MOD : v;
    endfunction

    function automatic logic [FW-1:0] field_product(logic [FW-1:0] x, logic [FW-1:0] y);
        logic [63:0] p;
        p = 64'(x) * 64'(y);
        return FW'(p % 64'(pfa_pkg::FIELD_MOD));
    endfunction

    // square-and-multiply from the lsb up over nbits exponent bits
    function automatic logic [FW-1:0] field_power(logic [FW-1:0] base,
                                                  logic [63:0] e, int nbits);
        logic [FW-1:0] acc;
        logic [FW-1:0] sq;
        acc = 30'd1;
        sq = base;
        for (int i = 0; i < nbits; i++)
        begin
            if (e[i])
                acc = field_product(acc, sq);
            sq = field_product(sq, sq);
        end
        return acc;
    endfunction

    function automatic logic [FW-1:0] field_result(logic [2:0] op,
                                                   logic [FW-1:0] lhs,
                                                   logic [FW-1:0] rhs,
                                                   logic [EXP_W-1:0] power_exp);
        logic [FW-1:0] a;
        logic [FW-1:0] b;
        logic [FW:0]   sum;
        a = fold_operand(lhs);
        b = fold_operand(rhs);
        case (op)
            pfa_pkg::OP_ADD:
            begin
                sum = {1'b0, a} + {1'b0, b};
                return (sum >= {1'b0, pfa_pkg::FIELD_MOD}) ?
                       FW'(sum - pfa_pkg::FIELD_MOD) : FW'(sum);
            end
            pfa_pkg::OP_SUB:
            begin
                sum = {1'b0, a} + {1'b0, pfa_pkg::FIELD_MOD - b};
                return (sum >= {1'b0, pfa_pkg::FIELD_MOD}) ?
                       FW'(sum - pfa_pkg::FIELD_MOD) : FW'(sum);
            end
            pfa_pkg::OP_MUL: return field_product(a, b);
            pfa_pkg::OP_DIV:
                return field_product(a, field_power(b, 64'(pfa_pkg::FIELD_MOD_MINUS2),
                                                    pfa_pkg::INV_EXP_BITS));
            pfa_pkg::OP_POW: return field_power(a, 64'(power_exp), EXP_W);
            pfa_pkg::OP_NEG: return (a == '0) ? '0 : pfa_pkg::FIELD_MOD - a;
            pfa_pkg::OP_INV:
                return field_power(a, 64'(pfa_pkg::FIELD_MOD_MINUS2), pfa_pkg::INV_EXP_BITS);
            default: return '0;
        endcase
    endfunction

    function automatic logic [FW-1:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return FW'($urandom_range(0, 3));
            1: return pfa_pkg::FIELD_MOD - FW'($urandom_range(1, 3));
            2: return pfa_pkg::FIELD_MOD + FW'($urandom_range(0, 3));
            3: return FIELD_MAX - FW'($urandom_range(0, 3));
            default: return FW'($urandom);
        endcase
    endfunction

    function automatic logic [EXP_W-1:0] pick_exponent();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: return EXP_W'($urandom_range(0, 20));
            1: return {EXP_W{1'b1}};
            2: return EXP_W'(pfa_pkg::FIELD_MOD_MINUS2);
            3: return EXP_W'(1) << $urandom_range(0, EXP_W - 1);
            default: return raw[EXP_W-1:0];
        endcase
    endfunction

    function automatic logic [2:0] pick_operation();
        return ($urandom_range(0, 49) == 0) ? OP_RESERVED : 3'($urandom_range(0, 6));
    endfunction

    task automatic report_mismatch(string what, logic [2:0] op,
                                   logic [FW-1:0] got, logic [FW-1:0] want);
        $display("mismatch: %s op %0d got %0d want %0d", what, op, got, want);
        mismatch_count++;
    endtask

    // called at a rising edge; returns at the edge that takes the word
    task automatic send_word(logic [2:0] op, logic [FW-1:0] lhs,
                             logic [FW-1:0] rhs, logic [EXP_W-1:0] power_exp,
                             logic fixed, logic [FW-1:0] want);
        pending_t entry;
        start <= 1'b1;
        operation <= op;
        left_operand <= lhs;
        right_operand <= rhs;
        exponent <= power_exp;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        entry.op = op;
        entry.want = fixed ? want : field_result(op, lhs, rhs, power_exp);
        pending_results.push_back(entry);
    endtask

    task automatic idle_gap(int idle_pct);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic await_drain();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        pending_t entry;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("result with no word pending", OP_RESERVED, result, '0);
            end
            else
            begin
                entry = pending_results.pop_front();
                if (result !== entry.want)
                    report_mismatch("result", entry.op, result, entry.want);
            end
        end
    end

    // counts cycles with no word taken and no result strobed
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (rst_n && ((start && !busy) || done))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int idle_pct [3];
        idle_pct = '{16, 79, 0};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_ROWS; i++)
        begin
            send_word(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].lhs, DIRECTED_ROWS[i].rhs,
                      DIRECTED_ROWS[i].power_exp, DIRECTED_ROWS[i].fixed,
                      DIRECTED_ROWS[i].want);
            idle_gap(30);
        end
        await_drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            for (int i = 0; i < WORDS_PER_PHASE; i++)
            begin
                idle_gap(idle_pct[phase]);
                send_word(pick_operation(), pick_operand(), pick_operand(), pick_exponent(),
                          1'b0, '0);
            end
            // hold off until every result of the phase is back
            await_drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
